[rtl/tlf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tlf_pkg;

    localparam int CHAR_W         = 8;
    localparam int TW_W           = 5;
    localparam int LINE_WIDTH_DEF = 10;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

    localparam logic [TW_W-1:0] TW_RESET = 5'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAB_DIV,
        ST_TAB_FILL,
        ST_SEARCH,
        ST_EMIT,
        ST_MOVE
    } tlf_state_t;

endpackage

`default_nettype wire

[rtl/tlf_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tlf_in_if import tlf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface tlf_out_if import tlf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/tlf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/text_line_folder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Line folder with tab expansion.
// feed carries one character per transaction; folded carries output characters,
// with last_of_run set on the final character that one input character causes.
// cfg_we/cfg_wdata set the tab spacing (reset 8, zero behaves as 1); write only
// while the block is idle.
// An ordinary character that does not fill the line gives no output. A character
// that fills the line starts a backward search for a blank, one RAM entry per
// cycle, then the line goes out at one character per cycle while folded does
// not stall, plus a newline, then the remainder is copied to the front at one
// entry per cycle. A tab finds its tab-stop phase by a bit-serial remainder,
// then fills blanks up to the next stop. Worst case is a tab with a wide stop
// that runs to the line end; the line RAM, with one write and one read port,
// sets the pace.
// feed.ready is high only between characters.
// Output sits in a register; a stall on folded holds the sequencer in place.
// Reset empties the line and restores tab spacing 8; buffered characters are
// never flushed on their own.
module text_line_folder import tlf_pkg::*; #(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [TW_W-1:0] cfg_wdata,
    tlf_in_if.sink               feed,
    tlf_out_if.source            folded
);

    localparam int CW = $clog2(LINE_WIDTH + 1);
    localparam int AW = $clog2(LINE_WIDTH);
    localparam int BW = $clog2(CW);
    localparam logic [CW-1:0] LW_C   = CW'(LINE_WIDTH);
    localparam logic [CW-1:0] LAST_C = CW'(LINE_WIDTH - 1);
    localparam logic [CW-1:0] ONE_C  = CW'(1);

    tlf_state_t state_reg, state_next;

    logic [TW_W-1:0]   tab_width_reg;
    logic [CW-1:0]     column_reg, column_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [TW_W-1:0]   rem_reg, rem_next;
    logic [BW-1:0]     bit_reg, bit_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     cut_reg, cut_next;
    logic              ok_reg, ok_next;
    logic              move_after_reg, move_after_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    logic [TW_W-1:0]   tw_eff;
    logic [TW_W:0]     trial;
    logic              trial_ge;
    logic              accept;
    logic              slot_free;
    logic              is_tab;
    logic              is_nl;
    logic [CW-1:0]     col_inc;
    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     idx_dec;
    logic              emit_more;
    logic              found_blank;
    logic              move_last;

    tlf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_WIDTH),
        .AW    (AW)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign tw_eff      = (tab_width_reg == '0) ? TW_W'(1) : tab_width_reg;
    assign accept      = feed.valid && feed.ready;
    assign slot_free   = !out_valid_reg || folded.ready;
    assign is_tab      = (feed.in_char == CH_TAB);
    assign is_nl       = (feed.in_char == CH_NL);
    assign col_inc     = column_reg + ONE_C;
    assign idx_inc     = idx_reg + ONE_C;
    assign idx_dec     = idx_reg - ONE_C;
    assign emit_more   = (idx_reg < cnt_reg);
    assign found_blank = (ram_rdata == CH_BLANK);
    assign move_last   = (idx_reg == LAST_C);

    // one remainder step: shift in the next bit of pos, subtract if it fits
    assign trial    = {rem_reg, pos_reg[bit_reg]};
    assign trial_ge = (trial >= {1'b0, tw_eff});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg <= TW_RESET;
        end
        else if (cfg_we)
        begin
            tab_width_reg <= cfg_wdata;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_tab)
                    begin
                        state_next = (col_inc == LW_C) ? ST_EMIT : ST_TAB_DIV;
                    end
                    else if (is_nl)
                    begin
                        state_next = (column_reg == '0) ? ST_IDLE : ST_EMIT;
                    end
                    else if (col_inc == LW_C)
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_TAB_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = ST_TAB_FILL;
                end
            end
            ST_TAB_FILL:
            begin
                if (pos_reg == LW_C)
                begin
                    state_next = ST_EMIT;
                end
                else if (rem_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (ok_reg && (found_blank || idx_reg == ONE_C))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!emit_more && slot_free)
                begin
                    state_next = move_after_reg ? ST_MOVE : ST_IDLE;
                end
            end
            ST_MOVE:
            begin
                if (ok_reg && move_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        column_next     = column_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        bit_next        = bit_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        cut_next        = cut_reg;
        ok_next         = ok_reg;
        move_after_next = move_after_reg;
        out_load        = 1'b0;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = column_reg[AW-1:0];
        ram_wdata       = feed.in_char;
        ram_raddr       = idx_reg[AW-1:0];
        feed.ready      = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = is_tab ? CH_BLANK : feed.in_char;
                    idx_next  = '0;
                    ok_next   = 1'b0;
                    move_after_next = 1'b0;
                    if (is_tab)
                    begin
                        cnt_next = LW_C;
                        pos_next = col_inc;
                        rem_next = '0;
                        bit_next = BW'(CW - 1);
                    end
                    else if (is_nl)
                    begin
                        cnt_next = column_reg;
                        if (column_reg == '0)
                        begin
                            column_next = '0;
                        end
                    end
                    else if (col_inc == LW_C)
                    begin
                        idx_next = LAST_C;
                    end
                    else
                    begin
                        column_next = col_inc;
                    end
                end
            end
            ST_TAB_DIV:
            begin
                rem_next = trial_ge ? TW_W'(trial - {1'b0, tw_eff}) : trial[TW_W-1:0];
                bit_next = bit_reg - BW'(1);
            end
            ST_TAB_FILL:
            begin
                if (pos_reg == LW_C)
                begin
                    cnt_next = LW_C;
                    idx_next = '0;
                    ok_next  = 1'b0;
                end
                else if (rem_reg == '0)
                begin
                    column_next = pos_reg;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg[AW-1:0];
                    ram_wdata = CH_BLANK;
                    pos_next  = pos_reg + ONE_C;
                    rem_next  = (rem_reg + TW_W'(1) == tw_eff) ? '0 : rem_reg + TW_W'(1);
                end
            end
            ST_SEARCH:
            begin
                if (!ok_reg)
                begin
                    ok_next = 1'b1;
                end
                else if (found_blank || idx_reg == ONE_C)
                begin
                    // a blank at position zero is no fold point; a blank in the
                    // last position leaves nothing to move
                    cnt_next        = found_blank ? idx_inc : LW_C;
                    cut_next        = idx_inc;
                    move_after_next = found_blank && (idx_reg != LAST_C);
                    idx_next        = '0;
                    ok_next         = 1'b0;
                end
                else
                begin
                    idx_next  = idx_dec;
                    ram_raddr = idx_dec[AW-1:0];
                end
            end
            ST_EMIT:
            begin
                if (emit_more)
                begin
                    if (!ok_reg)
                    begin
                        ok_next = 1'b1;
                    end
                    else if (slot_free)
                    begin
                        out_load      = 1'b1;
                        out_char_next = ram_rdata;
                        out_last_next = 1'b0;
                        idx_next      = idx_inc;
                        // prefetch the next entry so the line goes out back to back
                        if (idx_inc < cnt_reg)
                        begin
                            ram_raddr = idx_inc[AW-1:0];
                        end
                    end
                end
                else if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_char_next = CH_NL;
                    out_last_next = 1'b1;
                    if (move_after_reg)
                    begin
                        idx_next = cut_reg;
                        ok_next  = 1'b0;
                    end
                    else
                    begin
                        column_next = '0;
                    end
                end
            end
            ST_MOVE:
            begin
                if (!ok_reg)
                begin
                    ok_next = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(idx_reg - cut_reg);
                    ram_wdata = ram_rdata;
                    if (move_last)
                    begin
                        column_next = LW_C - cut_reg;
                    end
                    else
                    begin
                        idx_next  = idx_inc;
                        ram_raddr = idx_inc[AW-1:0];
                    end
                end
            end
            default:
            begin
                column_next = '0;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !folded.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            column_reg     <= '0;
            pos_reg        <= '0;
            rem_reg        <= '0;
            bit_reg        <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            cut_reg        <= '0;
            ok_reg         <= 1'b0;
            move_after_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            column_reg     <= column_next;
            pos_reg        <= pos_next;
            rem_reg        <= rem_next;
            bit_reg        <= bit_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            cut_reg        <= cut_next;
            ok_reg         <= ok_next;
            move_after_reg <= move_after_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign folded.valid       = out_valid_reg;
    assign folded.out_char    = out_char_reg;
    assign folded.last_of_run = out_last_reg;

`ifndef SYNTHESIS
    a_column_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg < LW_C)
        else $error("column ran past the line");

    a_search_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (idx_reg >= ONE_C && idx_reg < LW_C))
        else $error("blank search left the line");

    a_move_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |-> (cut_reg >= CW'(2) && idx_reg >= cut_reg
                                    && idx_reg < LW_C))
        else $error("remainder copy out of range");

    a_tab_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAB_FILL) |-> (rem_reg < tw_eff))
        else $error("tab phase not reduced");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !folded.ready) |=> $stable(out_char_reg))
        else $error("held output overwritten");
`endif

endmodule

`default_nettype wire

[dv/text_line_folder_tb.sv]
`timescale 1ns / 1ps

module text_line_folder_tb;
    import tlf_pkg::*;

    localparam int LW             = LINE_WIDTH_DEF;
    localparam int SETTLE_CYCLES  = 4 * LW;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 31;
    localparam int DIR_ROWS       = 29;

    typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

    // fixed rows carry up to three typed results in r0..r2
    typedef struct {
        row_kind_t   kind;
        logic [7:0]  val;
        bit          fixed;
        int          nres;
        logic [7:0]  r0;
        logic [7:0]  r1;
        logic [7:0]  r2;
    } stim_row_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eor;
    } out_beat_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    logic [TW_W-1:0] cfg_wdata = '0;

    tlf_in_if  feed_bus ();
    tlf_out_if fold_bus ();

    text_line_folder #(.LINE_WIDTH(LW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .feed      (feed_bus),
        .folded    (fold_bus)
    );

    // folding model state
    logic [7:0]      line_buf [LW];
    int              line_col = 0;
    logic [TW_W-1:0] tab_cfg = TW_RESET;
    logic [7:0]      run_chars [$];
    out_beat_t       exp_q [$];

    int        errors = 0;
    int        fed_count = 0;
    int        checked_count = 0;
    int        cfg_count = 0;
    int        idle_cycles = 0;
    int        stall_left = 0;
    bit        calm = 1'b0;
    out_beat_t want;

    stim_row_t       dir_rows [DIR_ROWS];
    stim_row_t       row;
    logic [TW_W-1:0] phase_tw [RANDOM_PHASES];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void emit_buf(input int count);
        for (int i = 0; i < count; i++)
            run_chars.push_back(line_buf[i]);
        if (count > 0)
            run_chars.push_back(CH_NL);
    endfunction

    // works out the characters one input causes and updates the line state
    function automatic void fold_step(input logic [7:0] c);
        int pos;
        int tw;
        int p;
        int cut;
        run_chars.delete();
        pos = line_col;
        tw = (tab_cfg == 0) ? 1 : int'(tab_cfg);
        if (pos >= LW)
            pos = 0;
        line_buf[pos] = c;
        if (c == CH_TAB)
        begin
            line_buf[pos] = CH_BLANK;
            pos++;
            while (pos < LW && pos % tw != 0)
            begin
                line_buf[pos] = CH_BLANK;
                pos++;
            end
            if (pos < LW)
                line_col = pos;
            else
            begin
                emit_buf(LW);
                line_col = 0;
            end
        end
        else if (c == CH_NL)
        begin
            emit_buf(pos);
            line_col = 0;
        end
        else
        begin
            pos++;
            if (pos < LW)
                line_col = pos;
            else
            begin
                // fold point: last blank, position 0 excluded
                p = LW - 1;
                while (p > 0 && line_buf[p] != CH_BLANK)
                    p--;
                cut = (p == 0) ? LW : p + 1;
                emit_buf(cut);
                line_col = 0;
                for (int i = cut; i < LW; i++)
                begin
                    line_buf[line_col] = line_buf[i];
                    line_col++;
                end
            end
        end
    endfunction

    function automatic void queue_run();
        out_beat_t b;
        foreach (run_chars[i])
        begin
            b.ch  = run_chars[i];
            b.eor = (i == run_chars.size() - 1);
            exp_q.push_back(b);
        end
    endfunction

    function automatic logic [7:0] pick_char();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50)
            return 8'($urandom_range(8'h61, 8'h7a));
        else if (k < 70)
            return CH_BLANK;
        else if (k < 78)
            return CH_TAB;
        else if (k < 86)
            return CH_NL;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic drive_char(input logic [7:0] c);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            feed_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        feed_bus.valid   <= 1'b1;
        feed_bus.in_char <= c;
        do @(posedge clk); while (!feed_bus.ready);
        fed_count++;
    endtask

    // hold the feed until every expected character is out and the block has settled
    task automatic quiesce();
        feed_bus.valid <= 1'b0;
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tab(input logic [TW_W-1:0] v);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tab_cfg = v;
        cfg_count++;
    endtask

    task automatic feed_random(input int count);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < count; i++)
        begin
            c = pick_char();
            drive_char(c);
            fold_step(c);
            queue_run();
        end
    endtask

    // output side: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            fold_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            fold_bus.ready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end
        else
            fold_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && fold_bus.valid && fold_bus.ready)
        begin
            if (exp_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction: expected none, actual out_char %02h last %0b",
                         $time, fold_bus.out_char, fold_bus.last_of_run);
            end
            else
            begin
                want = exp_q.pop_front();
                checked_count++;
                if (fold_bus.out_char !== want.ch)
                begin
                    errors++;
                    $display("%0t: out_char expected %02h actual %02h",
                             $time, want.ch, fold_bus.out_char);
                end
                if (fold_bus.last_of_run !== want.eor)
                begin
                    errors++;
                    $display("%0t: last_of_run expected %0b actual %0b",
                             $time, want.eor, fold_bus.last_of_run);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (feed_bus.valid && feed_bus.ready) || (fold_bus.valid && fold_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        feed_bus.valid   = 1'b0;
        feed_bus.in_char = '0;
        foreach (line_buf[i])
            line_buf[i] = '0;

        dir_rows = '{
            '{ROW_CHAR, CH_NL,    1'b1, 0, 8'h00, 8'h00, 8'h00},  // empty line
            '{ROW_CHAR, 8'h41,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, CH_NL,    1'b1, 2, 8'h41, CH_NL, 8'h00},
            '{ROW_CHAR, 8'h00,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, 8'hff,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, CH_NL,    1'b1, 3, 8'h00, 8'hff, CH_NL},
            '{ROW_CHAR, CH_TAB,   1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, 8'h78,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, 8'h79,    1'b0, 0, 8'h00, 8'h00, 8'h00},  // fold after the tab blanks
            '{ROW_CHAR, CH_NL,    1'b0, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, CH_BLANK, 1'b1, 0, 8'h00, 8'h00, 8'h00},  // blank at the line start
            '{ROW_CHAR, 8'h62,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, 8'h62,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, 8'h62,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, 8'h62,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, 8'h62,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, 8'h62,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, 8'h62,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, 8'h62,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, 8'h62,    1'b0, 0, 8'h00, 8'h00, 8'h00},  // no fold point, whole line
            '{ROW_CHAR, CH_TAB,   1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, CH_TAB,   1'b0, 0, 8'h00, 8'h00, 8'h00},  // tab runs off the line end
            '{ROW_CFG,  8'd0,     1'b0, 0, 8'h00, 8'h00, 8'h00},  // zero acts as one
            '{ROW_CHAR, 8'h61,    1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, CH_TAB,   1'b1, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CFG,  8'd31,    1'b0, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, CH_NL,    1'b0, 0, 8'h00, 8'h00, 8'h00},
            '{ROW_CHAR, CH_TAB,   1'b0, 0, 8'h00, 8'h00, 8'h00},  // wide stop fills the line
            '{ROW_CFG,  8'd16,    1'b0, 0, 8'h00, 8'h00, 8'h00}
        };
        phase_tw = '{5'd1, 5'd16, 5'd0, 5'd31, 5'($urandom_range(1, 16))};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
                write_tab(row.val[TW_W-1:0]);
            else
            begin
                drive_char(row.val);
                fold_step(row.val);
                if (row.fixed)
                begin
                    run_chars.delete();
                    if (row.nres > 0)
                        run_chars.push_back(row.r0);
                    if (row.nres > 1)
                        run_chars.push_back(row.r1);
                    if (row.nres > 2)
                        run_chars.push_back(row.r2);
                end
                queue_run();
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_tab(phase_tw[ph]);
            if (ph == RANDOM_PHASES - 1)
                calm = 1'b1;
            if (ph == 1)
            begin
                // let the output drain completely mid-phase
                feed_random(PHASE_ITEMS / 2);
                quiesce();
                feed_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end
            else
                feed_random(PHASE_ITEMS);
        end

        quiesce();

        $display("Fed %0d characters over %0d tab settings (zero, one, sixteen, 31 included);",
                 fed_count, cfg_count);
        $display("checked %0d folded characters, %0d mismatches.", checked_count, errors);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
